// ===== hw/rtl/srcmp_pkg.sv =====
// Shared types, codes and constants for the sensor raw compensation block.
`timescale 1ns / 1ps
`default_nettype none
package srcmp_pkg;

  // Configuration port geometry: 64-bit registers at 8-byte spacing.
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  // Register indexes.
  localparam logic [2:0] REG_TEMP       = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_PRESS_LAST = 3'd3;
  localparam logic [2:0] REG_HUM        = 3'd4;

  // Quantity codes.
  localparam logic [1:0] FUNC_TEMP   = 2'd0;
  localparam logic [1:0] FUNC_PRESS  = 2'd1;
  localparam logic [1:0] FUNC_HUM    = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Calibration register contents.
  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_last;
    logic [63:0] hum;
  } calib_t;

  // Sequencer steps; most of them pass through the shared multiplier.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T0, ST_T1, ST_T2, ST_T3,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
    ST_P8, ST_P9, ST_DIV, ST_P10, ST_P11, ST_P12, ST_P13, ST_P14,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8, ST_H9,
    ST_ZERO
  } step_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    step_e step;
    logic  en;
    logic  load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
    logic div_busy;
    logic div_zero;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/srcmp_regs.sv =====
// Calibration register file behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none
module srcmp_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [srcmp_pkg::AddrW-1:0]    paddr,
  input  wire logic [srcmp_pkg::DataW-1:0]    pwdata,
  output      logic [srcmp_pkg::DataW-1:0]    prdata,
  output      logic                           pready,
  output      srcmp_pkg::calib_t              calib_o
);

  srcmp_pkg::calib_t calib_q, calib_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign calib_o = calib_q;

  // Register write decode.
  always_comb begin
    calib_d = calib_q;
    if (wr_en) begin
      case (idx)
        srcmp_pkg::REG_TEMP:       calib_d.temp       = pwdata[47:0];
        srcmp_pkg::REG_PRESS_LOW:  calib_d.press_low  = pwdata;
        srcmp_pkg::REG_PRESS_HIGH: calib_d.press_high = pwdata;
        srcmp_pkg::REG_PRESS_LAST: calib_d.press_last = pwdata[15:0];
        srcmp_pkg::REG_HUM:        calib_d.hum        = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= '0;
    end else begin
      calib_q <= calib_d;
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      srcmp_pkg::REG_TEMP:       prdata = {16'b0, calib_q.temp};
      srcmp_pkg::REG_PRESS_LOW:  prdata = calib_q.press_low;
      srcmp_pkg::REG_PRESS_HIGH: prdata = calib_q.press_high;
      srcmp_pkg::REG_PRESS_LAST: prdata = {48'b0, calib_q.press_last};
      srcmp_pkg::REG_HUM:        prdata = calib_q.hum;
      default:                   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/srcmp_ctrl.sv =====
// Step sequencer that drives the compensation datapath.
`timescale 1ns / 1ps
`default_nettype none
module srcmp_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [1:0]            func_i,
  output      logic                  in_stall_o,
  input  wire srcmp_pkg::dp_status_t status_i,
  output      srcmp_pkg::dp_cmd_t    cmd_o
);

  srcmp_pkg::step_e state_q, state_d;
  logic final_step;
  logic en;

  // Steps that write the output register, or may do so, wait for a free slot.
  always_comb begin
    case (state_q)
      srcmp_pkg::ST_T3, srcmp_pkg::ST_P8, srcmp_pkg::ST_P14,
      srcmp_pkg::ST_H9, srcmp_pkg::ST_ZERO: final_step = 1'b1;
      default:                              final_step = 1'b0;
    endcase
  end

  assign en = !(final_step && status_i.out_busy);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srcmp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            srcmp_pkg::FUNC_TEMP:  state_d = srcmp_pkg::ST_T0;
            srcmp_pkg::FUNC_PRESS: state_d = srcmp_pkg::ST_P0;
            srcmp_pkg::FUNC_HUM:   state_d = srcmp_pkg::ST_H0;
            default:               state_d = srcmp_pkg::ST_ZERO;
          endcase
        end
      end
      srcmp_pkg::ST_T3, srcmp_pkg::ST_P14, srcmp_pkg::ST_H9,
      srcmp_pkg::ST_ZERO: begin
        if (en) state_d = srcmp_pkg::ST_IDLE;
      end
      srcmp_pkg::ST_P8: begin
        if (en) state_d = status_i.div_zero ? srcmp_pkg::ST_IDLE : srcmp_pkg::ST_P9;
      end
      srcmp_pkg::ST_DIV: begin
        if (!status_i.div_busy) state_d = srcmp_pkg::ST_P10;
      end
      default: state_d = srcmp_pkg::step_e'(state_q + 5'd1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srcmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output logic.
  always_comb begin
    cmd_o.step = state_q;
    cmd_o.en   = en;
    cmd_o.load = (state_q == srcmp_pkg::ST_IDLE) && in_valid_i;
    in_stall_o = (state_q != srcmp_pkg::ST_IDLE);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/srcmp_dp.sv =====
// Compensation datapath: shared multiplier, scratch registers, divider, result slot.
`timescale 1ns / 1ps
`default_nettype none
module srcmp_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire srcmp_pkg::dp_cmd_t    cmd_i,
  output      srcmp_pkg::dp_status_t status_o,
  input  wire srcmp_pkg::calib_t     calib_i,
  input  wire logic [1:0]            func_i,
  input  wire logic [19:0]           raw_sample_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [1:0]            quantity_o,
  output      logic signed [18:0]    reading_o,
  output      logic                  divide_fault_o
);

  function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  // Scratch and state registers.
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [31:0] fine_q, fine_d;
  logic [1:0]  func_q;
  logic [19:0] raw_q;
  logic        hi_q, hi_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  quant_q, quant_d;
  logic [18:0] res_q, res_d;
  logic        fault_q, fault_d;
  logic        out_wr;

  // Divider registers.
  logic [31:0] rem_q, rem_d, quot_q, quot_d, dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        div_busy_q, div_busy_d;
  logic [32:0] trial;

  // Calibration fields.
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'b0, calib_i.temp[15:0]};
  assign t2 = sx16(calib_i.temp[31:16]);
  assign t3 = sx16(calib_i.temp[47:32]);
  assign p1 = {16'b0, calib_i.press_low[15:0]};
  assign p2 = sx16(calib_i.press_low[31:16]);
  assign p3 = sx16(calib_i.press_low[47:32]);
  assign p4 = sx16(calib_i.press_low[63:48]);
  assign p5 = sx16(calib_i.press_high[15:0]);
  assign p6 = sx16(calib_i.press_high[31:16]);
  assign p7 = sx16(calib_i.press_high[47:32]);
  assign p8 = sx16(calib_i.press_high[63:48]);
  assign p9 = sx16(calib_i.press_last);
  assign h1 = {24'b0, calib_i.hum[7:0]};
  assign h2 = sx16(calib_i.hum[23:8]);
  assign h3 = {24'b0, calib_i.hum[31:24]};
  assign h4 = {{20{calib_i.hum[43]}}, calib_i.hum[43:32]};
  assign h5 = {{20{calib_i.hum[55]}}, calib_i.hum[55:44]};
  assign h6 = {{24{calib_i.hum[63]}}, calib_i.hum[63:56]};

  // Operand selection for the shared 32x32 multiplier (low word kept).
  logic [31:0] mul_a, mul_b, mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      srcmp_pkg::ST_T0: begin
        mul_a = {15'b0, raw_q[19:3]} - {15'b0, t1[15:0], 1'b0};
        mul_b = t2;
      end
      srcmp_pkg::ST_T1: begin
        mul_a = {16'b0, raw_q[19:4]} - t1;
        mul_b = {16'b0, raw_q[19:4]} - t1;
      end
      srcmp_pkg::ST_T2:  begin mul_a = b_q;         mul_b = t3;          end
      srcmp_pkg::ST_T3:  begin mul_a = a_q + b_q;   mul_b = 32'd5;       end
      srcmp_pkg::ST_P1:  begin mul_a = sra(a_q, 5'd2); mul_b = sra(a_q, 5'd2); end
      srcmp_pkg::ST_P2:  begin mul_a = sra(b_q, 5'd11); mul_b = p6;      end
      srcmp_pkg::ST_P3:  begin mul_a = a_q;         mul_b = p5;          end
      srcmp_pkg::ST_P5:  begin mul_a = p3;          mul_b = sra(b_q, 5'd13); end
      srcmp_pkg::ST_P6:  begin mul_a = p2;          mul_b = a_q;         end
      srcmp_pkg::ST_P7:  begin mul_a = 32'd32768 + d_q; mul_b = p1;     end
      srcmp_pkg::ST_P8: begin
        mul_a = (32'd1048576 - {12'b0, raw_q}) - sra(c_q, 5'd12);
        mul_b = 32'd3125;
      end
      srcmp_pkg::ST_P11: begin mul_a = {3'b0, b_q[31:3]}; mul_b = {3'b0, b_q[31:3]}; end
      srcmp_pkg::ST_P12: begin mul_a = p9;          mul_b = a_q;         end
      srcmp_pkg::ST_P13: begin mul_a = {2'b0, b_q[31:2]}; mul_b = p8;    end
      srcmp_pkg::ST_H1:  begin mul_a = h5;          mul_b = a_q;         end
      srcmp_pkg::ST_H2:  begin mul_a = a_q;         mul_b = h6;          end
      srcmp_pkg::ST_H3:  begin mul_a = a_q;         mul_b = h3;          end
      srcmp_pkg::ST_H4:  begin mul_a = c_q;         mul_b = d_q;         end
      srcmp_pkg::ST_H5:  begin mul_a = c_q;         mul_b = h2;          end
      srcmp_pkg::ST_H6:  begin mul_a = b_q;         mul_b = c_q;         end
      srcmp_pkg::ST_H7:  begin mul_a = sra(a_q, 5'd15); mul_b = sra(a_q, 5'd15); end
      srcmp_pkg::ST_H8:  begin mul_a = d_q;         mul_b = h1;          end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Step execution.
  logic [31:0] tmp;
  always_comb begin
    a_d = a_q;  b_d = b_q;  c_d = c_q;  d_d = d_q;
    fine_d = fine_q;
    hi_d = hi_q;
    out_wr = 1'b0;
    res_d = '0;
    fault_d = 1'b0;
    tmp = '0;
    if (cmd_i.en) begin
      case (cmd_i.step)
        srcmp_pkg::ST_T0: a_d = sra(mul_p, 5'd11);
        srcmp_pkg::ST_T1: b_d = sra(mul_p, 5'd12);
        srcmp_pkg::ST_T2: b_d = sra(mul_p, 5'd14);
        srcmp_pkg::ST_T3: begin
          fine_d = a_q + b_q;
          tmp = sra(mul_p + 32'd128, 5'd8);
          out_wr = 1'b1;
          if ($signed(tmp) < -32'sd65536)      res_d = 19'h70000;
          else if ($signed(tmp) > 32'sd262143) res_d = 19'h3FFFF;
          else                                 res_d = tmp[18:0];
        end
        srcmp_pkg::ST_P0: a_d = sra(fine_q, 5'd1) - 32'd64000;
        srcmp_pkg::ST_P1: b_d = mul_p;
        srcmp_pkg::ST_P2: c_d = mul_p;
        srcmp_pkg::ST_P3: c_d = c_q + {mul_p[30:0], 1'b0};
        srcmp_pkg::ST_P4: c_d = sra(c_q, 5'd2) + {p4[15:0], 16'b0};
        srcmp_pkg::ST_P5: d_d = sra(mul_p, 5'd3);
        srcmp_pkg::ST_P6: d_d = sra(d_q + sra(mul_p, 5'd1), 5'd18);
        srcmp_pkg::ST_P7: d_d = sra(mul_p, 5'd15);
        srcmp_pkg::ST_P8: begin
          if (d_q == '0) begin
            out_wr  = 1'b1;
            fault_d = 1'b1;
          end else begin
            b_d = mul_p;
          end
        end
        srcmp_pkg::ST_P9:  hi_d = b_q[31];
        srcmp_pkg::ST_P10: b_d = hi_q ? {quot_q[30:0], 1'b0} : quot_q;
        srcmp_pkg::ST_P11: a_d = {13'b0, mul_p[31:13]};
        srcmp_pkg::ST_P12: a_d = sra(mul_p, 5'd12);
        srcmp_pkg::ST_P13: c_d = sra(mul_p, 5'd13);
        srcmp_pkg::ST_P14: begin
          tmp = b_q + sra(a_q + c_q + p7, 5'd4);
          out_wr = 1'b1;
          res_d = (tmp > 32'd262143) ? 19'h3FFFF : tmp[18:0];
        end
        srcmp_pkg::ST_H0: a_d = fine_q - 32'd76800;
        srcmp_pkg::ST_H1: begin
          b_d = sra({2'b0, raw_q[15:0], 14'b0} - {h4[11:0], 20'b0} - mul_p
                    + 32'd16384, 5'd15);
        end
        srcmp_pkg::ST_H2: c_d = sra(mul_p, 5'd10);
        srcmp_pkg::ST_H3: d_d = sra(mul_p, 5'd11) + 32'd32768;
        srcmp_pkg::ST_H4: c_d = sra(mul_p, 5'd10) + 32'd2097152;
        srcmp_pkg::ST_H5: c_d = sra(mul_p + 32'd8192, 5'd14);
        srcmp_pkg::ST_H6: a_d = mul_p;
        srcmp_pkg::ST_H7: d_d = sra(mul_p, 5'd7);
        srcmp_pkg::ST_H8: a_d = a_q - sra(mul_p, 5'd4);
        srcmp_pkg::ST_H9: begin
          out_wr = 1'b1;
          if (a_q[31])                       tmp = '0;
          else if (a_q > 32'd419430400)      tmp = 32'd419430400;
          else                               tmp = a_q;
          res_d = {2'b0, tmp[28:12]};
        end
        srcmp_pkg::ST_ZERO: out_wr = 1'b1;
        default: ;
      endcase
    end
  end

  // Radix-2 restoring divider, one quotient bit per cycle.
  assign trial = {rem_q, quot_q[31]} - {1'b0, dvs_q};
  always_comb begin
    rem_d = rem_q;  quot_d = quot_q;  dvs_d = dvs_q;
    cnt_d = cnt_q;  div_busy_d = div_busy_q;
    if (cmd_i.step == srcmp_pkg::ST_P9) begin
      rem_d      = '0;
      quot_d     = b_q[31] ? b_q : {b_q[30:0], 1'b0};
      dvs_d      = d_q;
      cnt_d      = 5'd31;
      div_busy_d = 1'b1;
    end else if (div_busy_q) begin
      if (!trial[32]) begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = {rem_q[30:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) div_busy_d = 1'b0;
    end
  end

  // Output slot.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    quant_d = quant_q;
    if (out_wr) begin
      out_valid_d = 1'b1;
      quant_d     = func_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      div_busy_q  <= 1'b0;
      fine_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      div_busy_q  <= div_busy_d;
      fine_q      <= fine_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;  b_q <= b_d;  c_q <= c_d;  d_q <= d_d;
    hi_q <= hi_d;
    rem_q <= rem_d;  quot_q <= quot_d;  dvs_q <= dvs_d;  cnt_q <= cnt_d;
    quant_q <= quant_d;
    if (cmd_i.load) begin
      func_q <= func_i;
      raw_q  <= raw_sample_i;
    end
    if (out_wr) begin
      res_q   <= res_d;
      fault_q <= fault_d;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign status_o.div_busy = div_busy_q;
  assign status_o.div_zero = (d_q == '0);

  assign out_valid_o    = out_valid_q;
  assign quantity_o     = quant_q;
  assign reading_o      = $signed(res_q);
  assign divide_fault_o = fault_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sensor_raw_compensation.sv =====
// Top level of the sensor raw-reading compensation block.
//
// Input channel: one transaction carries func_i (0 temperature, 1 pressure,
// 2 humidity) and a 20-bit raw_sample_i. Output channel: one transaction per
// input with quantity_o, signed reading_o and divide_fault_o.
// One item is processed at a time by a step sequencer around a single shared
// 32x32 multiplier. Pressure also passes through the radix-2 divider, which
// gives 32 quotient bits; a zero divisor ends the item without a division.
// The sequencer returns to idle at the edge that writes the result, and the
// next item can be accepted from then on.
// in_stall_o is high while an item is being worked on.
// A finished result waits in an output register; the next item is accepted
// meanwhile, and its final step waits while out_stall_i holds that register.
// Reset clears the calibration registers, the stored fine temperature, the
// sequencer state and the valid and divider busy flags; no output is valid after reset.
// Calibration is written through the APB-style port at byte address 8*i.
`timescale 1ns / 1ps
`default_nettype none
module sensor_raw_compensation (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [1:0]                  func_i,
  input  wire logic [19:0]                 raw_sample_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [1:0]                  quantity_o,
  output      logic signed [18:0]          reading_o,
  output      logic                        divide_fault_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [srcmp_pkg::AddrW-1:0] paddr,
  input  wire logic [srcmp_pkg::DataW-1:0] pwdata,
  output      logic [srcmp_pkg::DataW-1:0] prdata,
  output      logic                        pready
);

  srcmp_pkg::calib_t     calib;
  srcmp_pkg::dp_cmd_t    cmd;
  srcmp_pkg::dp_status_t status;

  srcmp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .calib_o (calib)
  );

  srcmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srcmp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .calib_i        (calib),
    .func_i         (func_i),
    .raw_sample_i   (raw_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .quantity_o     (quantity_o),
    .reading_o      (reading_o),
    .divide_fault_o (divide_fault_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/srcmp_checker.sv =====
// Port-level checker for the compensation block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module srcmp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [1:0]        quantity_o,
  input wire logic signed [18:0] reading_o,
  input wire logic              divide_fault_o
);

  // A stalled result transaction holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reading_o)
      && $stable(quantity_o) && $stable(divide_fault_o))
    else $error("stalled result changed");

  // The block is busy right after taking an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after accepting a transaction");

  // A divide fault only comes with a zero pressure reading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |->
      quantity_o == srcmp_pkg::FUNC_PRESS && reading_o == 19'sd0)
    else $error("bad divide fault result");

  // Humidity stays within 0 to 100 percent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quantity_o == srcmp_pkg::FUNC_HUM |->
      reading_o >= 19'sd0 && reading_o <= 19'sd102400)
    else $error("humidity out of range");

  // The unused code gives a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quantity_o == srcmp_pkg::FUNC_UNUSED |->
      reading_o == 19'sd0 && !divide_fault_o)
    else $error("unused code gave a nonzero result");

endmodule

bind sensor_raw_compensation srcmp_checker u_srcmp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .quantity_o     (quantity_o),
  .reading_o      (reading_o),
  .divide_fault_o (divide_fault_o)
);
`default_nettype wire
